/* design/srr_pkg.sv */
package srr_pkg;

  localparam int unsigned RecordCap    = 9000;
  localparam int unsigned EscapeBudget = 302;

  localparam int OffsetWidth = 14;
  localparam int ExtWidth    = 10;
  localparam int EscWidth    = 9;

  localparam logic [OffsetWidth-1:0] RECORD_CAP    = OffsetWidth'(RecordCap);
  localparam logic [EscWidth-1:0]    ESCAPE_BUDGET = EscWidth'(EscapeBudget);

  localparam logic [1:0] PH_NORMAL = 2'd0;
  localparam logic [1:0] PH_EXT    = 2'd1;
  localparam logic [1:0] PH_ESC    = 2'd2;
  localparam logic [1:0] PH_CHK    = 2'd3;

  localparam logic [1:0] MODE_ANY_NUL = 2'd0;
  localparam logic [1:0] MODE_ESCAPES = 2'd1;

  localparam logic [7:0] BYTE_NUL       = 8'd0;
  localparam logic [7:0] BYTE_EXTENSION = 8'd20;
  localparam logic [7:0] BYTE_ESCAPE    = 8'd18;

  localparam logic CFG_RECORD_MODE      = 1'b0;
  localparam logic CFG_EXTENSION_LENGTH = 1'b1;

  typedef struct packed {
    logic                   write_valid;
    logic [OffsetWidth-1:0] write_offset;
    logic [7:0]             write_data;
    logic                   record_done;
    logic [OffsetWidth-1:0] record_length;
    logic [7:0]             checksum_value;
    logic                   record_aborted;
  } result_t;

endpackage

/* design/serial_record_receiver_unit.sv */
// Serial record receiver.
// Input channel: in_valid/in_ready carry one received byte (rx_byte) per beat.
// Output channel: out_valid/out_ready carry one result beat for every input
// beat: a buffer write (write_valid, write_offset, write_data) and the record
// status (record_done, record_length, checksum_value, record_aborted).
// Configuration: cfg_we writes cfg_data into register cfg_index (0 is
// record_mode, 1 is extension_length); write only while no beat is in flight.
// An input beat passes an input register and a result register before its result beat.
// Throughput is one beat per cycle while the receiver takes every result; the record
// state updates as a byte moves from the input register into the result register.
// When the receiver stalls, the result register holds its beat and the input
// register still takes one more byte; after that in_ready drops until the
// receiver takes the waiting result.
// Reset clears both registers' valid flags, the configuration registers and
// the record state, so the next byte starts a new record at offset 0.
module serial_record_receiver_unit
  import srr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [ExtWidth-1:0]    cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             rx_byte,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   write_valid,
  output logic [OffsetWidth-1:0] write_offset,
  output logic [7:0]             write_data,
  output logic                   record_done,
  output logic [OffsetWidth-1:0] record_length,
  output logic [7:0]             checksum_value,
  output logic                   record_aborted
);

  logic [1:0]             record_mode;
  logic [ExtWidth-1:0]    extension_length;

  logic                   in_full;
  logic [7:0]             in_byte;

  logic [1:0]             phase;
  logic [OffsetWidth-1:0] byte_offset;
  logic [ExtWidth-1:0]    extension_remaining;
  logic [EscWidth-1:0]    escape_count;
  logic [OffsetWidth-1:0] final_length;

  logic [1:0]             phase_next;
  logic [OffsetWidth-1:0] byte_offset_next;
  logic [ExtWidth-1:0]    extension_remaining_next;
  logic [EscWidth-1:0]    escape_count_next;
  logic [OffsetWidth-1:0] final_length_next;

  logic                   advance;
  logic [OffsetWidth-1:0] offset_inc;
  logic [ExtWidth-1:0]    remaining_dec;
  logic [EscWidth-1:0]    escape_inc;
  logic                   cap_hit;
  result_t                result_next;
  result_t                result;

  assign advance   = in_full && (!out_valid || out_ready);
  assign in_ready  = !in_full || advance;

  assign offset_inc    = byte_offset + OffsetWidth'(1);
  assign remaining_dec = extension_remaining - ExtWidth'(1);
  assign escape_inc    = escape_count + EscWidth'(1);
  assign cap_hit       = offset_inc >= RECORD_CAP;

  always_comb begin
    phase_next               = phase;
    byte_offset_next         = byte_offset;
    extension_remaining_next = extension_remaining;
    escape_count_next        = escape_count;
    final_length_next        = final_length;
    result_next              = '0;

    if (phase != PH_CHK) begin
      result_next.write_valid  = 1'b1;
      result_next.write_offset = byte_offset;
      result_next.write_data   = in_byte;
    end

    unique case (phase)
      PH_CHK: begin
        result_next.record_done    = 1'b1;
        result_next.record_length  = final_length;
        result_next.checksum_value = in_byte;
        phase_next                 = PH_NORMAL;
        byte_offset_next           = '0;
        extension_remaining_next   = '0;
        escape_count_next          = '0;
        final_length_next          = '0;
      end
      PH_EXT: begin
        byte_offset_next         = offset_inc;
        extension_remaining_next = remaining_dec;
        if (remaining_dec == '0) begin
          phase_next = cap_hit ? PH_CHK : PH_NORMAL;
          if (cap_hit) begin
            final_length_next = offset_inc;
          end
        end
      end
      PH_ESC: begin
        byte_offset_next  = offset_inc;
        escape_count_next = escape_inc;
        if (escape_inc >= ESCAPE_BUDGET) begin
          result_next.record_done    = 1'b1;
          result_next.record_aborted = 1'b1;
          phase_next                 = PH_NORMAL;
          byte_offset_next           = '0;
          extension_remaining_next   = '0;
          escape_count_next          = '0;
          final_length_next          = '0;
        end else begin
          phase_next = cap_hit ? PH_CHK : PH_NORMAL;
          if (cap_hit) begin
            final_length_next = offset_inc;
          end
        end
      end
      default: begin
        priority if (in_byte == BYTE_NUL &&
                     (record_mode == MODE_ANY_NUL || byte_offset > OffsetWidth'(1))) begin
          final_length_next = byte_offset;
          phase_next        = PH_CHK;
        end else if (in_byte == BYTE_EXTENSION && record_mode == MODE_ESCAPES &&
                     extension_length != '0) begin
          byte_offset_next         = offset_inc;
          extension_remaining_next = extension_length;
          phase_next               = PH_EXT;
        end else if (in_byte == BYTE_ESCAPE && record_mode == MODE_ESCAPES) begin
          byte_offset_next = offset_inc;
          phase_next       = PH_ESC;
        end else begin
          byte_offset_next = offset_inc;
          phase_next       = cap_hit ? PH_CHK : PH_NORMAL;
          if (cap_hit) begin
            final_length_next = offset_inc;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      record_mode      <= MODE_ANY_NUL;
      extension_length <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RECORD_MODE:      record_mode      <= cfg_data[1:0];
        CFG_EXTENSION_LENGTH: extension_length <= cfg_data;
        default:              record_mode      <= record_mode;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full             <= 1'b0;
      out_valid           <= 1'b0;
      phase               <= PH_NORMAL;
      byte_offset         <= '0;
      extension_remaining <= '0;
      escape_count        <= '0;
      final_length        <= '0;
    end else begin
      if (in_ready) begin
        in_full <= in_valid;
      end
      if (advance) begin
        out_valid           <= 1'b1;
        phase               <= phase_next;
        byte_offset         <= byte_offset_next;
        extension_remaining <= extension_remaining_next;
        escape_count        <= escape_count_next;
        final_length        <= final_length_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte <= rx_byte;
    end
    if (advance) begin
      result <= result_next;
    end
  end

  assign write_valid    = result.write_valid;
  assign write_offset   = result.write_offset;
  assign write_data     = result.write_data;
  assign record_done    = result.record_done;
  assign record_length  = result.record_length;
  assign checksum_value = result.checksum_value;
  assign record_aborted = result.record_aborted;

endmodule
